FILE: rtl/grffa_pkg.sv
// Shared types, constants and control structures of the grid rectangle allocator.
package grffa_pkg;

    // Default grid bounds handed to the top-level parameters.
    localparam int MAX_COLS_DEF = 16;
    localparam int MAX_ROWS_DEF = 16;

    // Fixed field widths of the transactions and registers.
    localparam int KIND_W = 2;
    localparam int POS_W  = 4;
    localparam int SIZE_W = 5;
    localparam int CFG_W  = 5;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register indexes of the configuration port.
    localparam logic REG_IDX_GRID_WIDTH  = 1'b0;
    localparam logic REG_IDX_GRID_HEIGHT = 1'b1;

    // Register reset values.
    localparam logic [CFG_W-1:0] GRID_WIDTH_RST  = 5'd16;
    localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = 5'd16;

    // Request operations.
    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC = 2'd0,
        KIND_MARK  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_CHECK = 2'd3
    } kind_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ALLOC_ROWS,
        ST_ALLOC_FIT,
        ST_ALLOC_WRITE,
        ST_REGION_READ,
        ST_REGION_WRITE,
        ST_DONE
    } state_t;

    // First row of a row walk.
    typedef enum logic [1:0] {
        BASE_TOP,
        BASE_SCAN,
        BASE_SCAN_NEXT
    } walk_base_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       walk_start;
        walk_base_t walk_base;
        logic       walk_write;
        logic       walk_set;
        logic       take_fit;
        logic       scan_next;
        logic       mark_ok;
        logic       out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        kind_t kind;
        logic  region_ok;
        logic  alloc_ok;
        logic  walk_done;
        logic  fit_any;
        logic  region_free;
        logic  scan_more;
    } dp_status_t;

endpackage

FILE: rtl/grffa_regs.sv
// Configuration registers behind the APB-style port.
module grffa_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [grffa_pkg::APB_AW-1:0] paddr,
    input  logic [grffa_pkg::APB_DW-1:0] pwdata,
    output logic [grffa_pkg::APB_DW-1:0] prdata,
    output logic                         pready,
    output logic [grffa_pkg::CFG_W-1:0]  grid_width,
    output logic [grffa_pkg::CFG_W-1:0]  grid_height
);
    import grffa_pkg::*;

    logic [CFG_W-1:0] grid_width_reg;
    logic [CFG_W-1:0] grid_height_reg;
    logic             wr_en;
    logic             reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes complete in the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= GRID_WIDTH_RST;
            grid_height_reg <= GRID_HEIGHT_RST;
        end else if (wr_en) begin
            if (reg_idx == REG_IDX_GRID_WIDTH) begin
                grid_width_reg <= pwdata[CFG_W-1:0];
            end else begin
                grid_height_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    // Read data selection.
    always_comb begin
        unique case (reg_idx)
            REG_IDX_GRID_WIDTH:  prdata = {{(APB_DW-CFG_W){1'b0}}, grid_width_reg};
            REG_IDX_GRID_HEIGHT: prdata = {{(APB_DW-CFG_W){1'b0}}, grid_height_reg};
            default:             prdata = '0;
        endcase
    end

    assign grid_width  = grid_width_reg;
    assign grid_height = grid_height_reg;

endmodule

FILE: rtl/grffa_dp.sv
// Datapath: occupancy row memory, row walker, fit search and result register.
module grffa_dp #(
    parameter int MAX_COLS = grffa_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = grffa_pkg::MAX_ROWS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [grffa_pkg::KIND_W-1:0] s_kind,
    input  logic [grffa_pkg::POS_W-1:0]  s_rect_left,
    input  logic [grffa_pkg::POS_W-1:0]  s_rect_top,
    input  logic [grffa_pkg::SIZE_W-1:0] s_rect_width,
    input  logic [grffa_pkg::SIZE_W-1:0] s_rect_height,
    input  logic [grffa_pkg::CFG_W-1:0]  grid_width,
    input  logic [grffa_pkg::CFG_W-1:0]  grid_height,
    input  grffa_pkg::dp_cmd_t           cmd,
    output grffa_pkg::dp_status_t        status,
    output logic                         m_ok,
    output logic [grffa_pkg::POS_W-1:0]  m_place_left,
    output logic [grffa_pkg::POS_W-1:0]  m_place_top
);
    import grffa_pkg::*;

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int CW    = ((COL_W + 1 > SIZE_W) ? COL_W + 1 : SIZE_W) + 1;
    localparam int RW    = ((ROW_W + 1 > SIZE_W) ? ROW_W + 1 : SIZE_W) + 1;

    // Occupancy rows and their valid bits; an unwritten row reads as free.
    logic [MAX_COLS-1:0] mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] vld_reg;
    logic [MAX_COLS-1:0] rd_data_reg;
    logic                rd_vld_reg;

    // Captured request.
    kind_t             kind_reg;
    logic [POS_W-1:0]  req_left_reg;
    logic [POS_W-1:0]  req_top_reg;
    logic [SIZE_W-1:0] req_w_reg;
    logic [SIZE_W-1:0] req_h_reg;

    // Row walker.
    logic [ROW_W-1:0]    row_reg;
    logic [SIZE_W-1:0]   cnt_reg;
    logic                pend_reg;
    logic [ROW_W-1:0]    pend_row_reg;
    logic [MAX_COLS-1:0] acc_reg;

    // Allocation scan and result.
    logic [ROW_W-1:0] scan_y_reg;
    logic [COL_W-1:0] found_x_reg;
    logic [ROW_W-1:0] found_y_reg;
    logic             res_ok_reg;
    logic             out_ok_reg;
    logic [POS_W-1:0] out_left_reg;
    logic [POS_W-1:0] out_top_reg;

    logic [CW-1:0]         cols_act;
    logic [RW-1:0]         rows_act;
    logic [CW-1:0]         w_ext;
    logic [RW-1:0]         h_ext;
    logic [MAX_COLS-1:0]   col_mask;
    logic [MAX_COLS-1:0]   w_mask;
    logic [MAX_COLS-1:0]   span;
    logic [CW-1:0]         span_left;
    logic [2*MAX_COLS-1:0] occ_ext;
    logic [MAX_COLS-1:0]   fit_vec;
    logic [COL_W-1:0]      fit_x;
    logic [ROW_W-1:0]      walk_base_row;
    logic [ROW_W+POS_W-1:0] top_ext;
    logic [COL_W+POS_W-1:0] fx_ext;
    logic [ROW_W+POS_W-1:0] fy_ext;
    logic [MAX_COLS-1:0]   rd_row;

    // Active grid size, limited to the storage bounds.
    always_comb begin
        cols_act = (CW'(grid_width) > CW'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(grid_width);
        rows_act = (RW'(grid_height) > RW'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(grid_height);
        w_ext    = CW'(req_w_reg);
        h_ext    = RW'(req_h_reg);
    end

    // Bounds checks for the two request classes.
    assign status.kind      = kind_reg;
    assign status.region_ok = (req_w_reg != '0) && (req_h_reg != '0)
                              && (CW'(req_left_reg) + w_ext <= cols_act)
                              && (RW'(req_top_reg) + h_ext <= rows_act);
    assign status.alloc_ok  = (req_w_reg != '0) && (req_h_reg != '0)
                              && (w_ext <= cols_act) && (h_ext <= rows_act);
    assign status.scan_more = (RW'(scan_y_reg) + RW'(1) + h_ext <= rows_act);
    assign status.walk_done = (cnt_reg == '0) && !pend_reg;

    // Column masks: active columns, width run, and the region span.
    always_comb begin
        span_left = (kind_reg == KIND_ALLOC) ? CW'(found_x_reg) : CW'(req_left_reg);
        for (int c = 0; c < MAX_COLS; c++) begin
            col_mask[c] = (CW'(c) < cols_act);
            w_mask[c]   = (CW'(c) < w_ext);
            span[c]     = (CW'(c) >= span_left) && (CW'(c) < span_left + w_ext);
        end
    end

    assign status.region_free = ~|(acc_reg & span);

    // First-fit search over the merged rows of one candidate band.
    always_comb begin
        occ_ext = {{MAX_COLS{1'b1}}, acc_reg | ~col_mask};
        for (int x = 0; x < MAX_COLS; x++) begin
            fit_vec[x] = ~|(occ_ext[x +: MAX_COLS] & w_mask);
        end
        fit_x = '0;
        for (int x = MAX_COLS - 1; x >= 0; x--) begin
            if (fit_vec[x]) begin
                fit_x = COL_W'(x);
            end
        end
    end

    assign status.fit_any = |fit_vec;

    // Start row of a walk.
    always_comb begin
        top_ext = {{ROW_W{1'b0}}, req_top_reg};
        unique case (cmd.walk_base)
            BASE_TOP:       walk_base_row = top_ext[ROW_W-1:0];
            BASE_SCAN:      walk_base_row = scan_y_reg;
            BASE_SCAN_NEXT: walk_base_row = scan_y_reg + ROW_W'(1);
            default:        walk_base_row = scan_y_reg;
        endcase
    end

    // Request capture and scan bookkeeping.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg     <= kind_t'(s_kind);
            req_left_reg <= s_rect_left;
            req_top_reg  <= s_rect_top;
            req_w_reg    <= s_rect_width;
            req_h_reg    <= s_rect_height;
            scan_y_reg   <= '0;
            found_x_reg  <= '0;
            found_y_reg  <= '0;
            res_ok_reg   <= 1'b0;
        end else begin
            if (cmd.scan_next) begin
                scan_y_reg <= scan_y_reg + ROW_W'(1);
            end
            if (cmd.take_fit) begin
                found_x_reg <= fit_x;
                found_y_reg <= scan_y_reg;
            end
            if (cmd.mark_ok) begin
                res_ok_reg <= 1'b1;
            end
        end
    end

    // Row walker control: one row read issued per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
        end else if (cmd.walk_start) begin
            cnt_reg  <= req_h_reg;
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= (cnt_reg != '0);
            if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - SIZE_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.walk_start) begin
            row_reg <= walk_base_row;
        end else if (cnt_reg != '0) begin
            row_reg <= row_reg + ROW_W'(1);
        end
        pend_row_reg <= row_reg;
    end

    // Registered memory read.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[row_reg];
        rd_vld_reg  <= vld_reg[row_reg];
    end

    assign rd_row = rd_vld_reg ? rd_data_reg : '0;

    // Returned rows are merged into the band or written back modified.
    always_ff @(posedge aclk) begin
        if (cmd.walk_start) begin
            acc_reg <= '0;
        end else if (pend_reg && !cmd.walk_write) begin
            acc_reg <= acc_reg | rd_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_reg && cmd.walk_write) begin
            mem[pend_row_reg] <= cmd.walk_set ? (rd_row | span) : (rd_row & ~span);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pend_reg && cmd.walk_write) begin
            vld_reg[pend_row_reg] <= 1'b1;
        end
    end

    // Output register; allocate reports the found place, others echo the request.
    always_comb begin
        fx_ext = {{POS_W{1'b0}}, found_x_reg};
        fy_ext = {{POS_W{1'b0}}, found_y_reg};
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_ok_reg <= res_ok_reg;
            if (kind_reg == KIND_ALLOC) begin
                out_left_reg <= fx_ext[POS_W-1:0];
                out_top_reg  <= fy_ext[POS_W-1:0];
            end else begin
                out_left_reg <= req_left_reg;
                out_top_reg  <= req_top_reg;
            end
        end
    end

    assign m_ok         = out_ok_reg;
    assign m_place_left = out_left_reg;
    assign m_place_top  = out_top_reg;

endmodule

FILE: rtl/grffa_ctrl.sv
// Controller state machine sequencing the row walks of each request.
module grffa_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  grffa_pkg::dp_status_t status,
    output grffa_pkg::dp_cmd_t    cmd
);
    import grffa_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    // State and result-valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.walk_base = BASE_TOP;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (status.kind == KIND_ALLOC) begin
                    if (status.alloc_ok) begin
                        cmd.walk_start = 1'b1;
                        cmd.walk_base  = BASE_SCAN;
                        state_next     = ST_ALLOC_ROWS;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else if (!status.region_ok) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.walk_start = 1'b1;
                    cmd.walk_base  = BASE_TOP;
                    state_next     = (status.kind == KIND_CHECK) ? ST_REGION_READ
                                                                 : ST_REGION_WRITE;
                end
            end
            ST_ALLOC_ROWS: begin
                if (status.walk_done) begin
                    state_next = ST_ALLOC_FIT;
                end
            end
            ST_ALLOC_FIT: begin
                if (status.fit_any) begin
                    cmd.take_fit   = 1'b1;
                    cmd.walk_start = 1'b1;
                    cmd.walk_base  = BASE_SCAN;
                    state_next     = ST_ALLOC_WRITE;
                end else if (status.scan_more) begin
                    cmd.scan_next  = 1'b1;
                    cmd.walk_start = 1'b1;
                    cmd.walk_base  = BASE_SCAN_NEXT;
                    state_next     = ST_ALLOC_ROWS;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_ALLOC_WRITE: begin
                cmd.walk_write = 1'b1;
                cmd.walk_set   = 1'b1;
                if (status.walk_done) begin
                    cmd.mark_ok = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_REGION_READ: begin
                if (status.walk_done) begin
                    cmd.mark_ok = status.region_free;
                    state_next  = ST_DONE;
                end
            end
            ST_REGION_WRITE: begin
                cmd.walk_write = 1'b1;
                cmd.walk_set   = (status.kind == KIND_MARK);
                if (status.walk_done) begin
                    cmd.mark_ok = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid holds until the receiver takes the transaction.
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: rtl/grid_rect_first_fit_allocator.sv
// Top level of the two-dimensional first-fit rectangle allocator.
//
// Usage: a request transaction (s_kind, s_rect_*) enters on s_valid/s_ready;
// one result transaction (m_ok, m_place_left, m_place_top) leaves on
// m_valid/m_ready for every request. Requests are handled one at a time.
// Grid size registers sit on the APB-style port (grid_width at 0x0,
// grid_height at 0x4); write them only while the block is idle (not enforced).
//
// Mark, clear and check walk the rows of the region; a request out of
// bounds skips the walk. Allocate walks each candidate row band in turn
// and walks the band found once more to mark the place, reading one row
// per cycle through the memory port.
// The next request is taken in the cycle after the result is loaded.
//
// Reset clears the grid at once through per-row valid bits and sets both
// size registers to 16. A new request is taken while an earlier result
// still waits; when the receiver stalls, the next result waits in the
// controller's final state until the output register frees up.
module grid_rect_first_fit_allocator #(
    parameter int MAX_COLS = grffa_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = grffa_pkg::MAX_ROWS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [grffa_pkg::KIND_W-1:0] s_kind,
    input  logic [grffa_pkg::POS_W-1:0]  s_rect_left,
    input  logic [grffa_pkg::POS_W-1:0]  s_rect_top,
    input  logic [grffa_pkg::SIZE_W-1:0] s_rect_width,
    input  logic [grffa_pkg::SIZE_W-1:0] s_rect_height,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_ok,
    output logic [grffa_pkg::POS_W-1:0]  m_place_left,
    output logic [grffa_pkg::POS_W-1:0]  m_place_top,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [grffa_pkg::APB_AW-1:0] paddr,
    input  logic [grffa_pkg::APB_DW-1:0] pwdata,
    output logic [grffa_pkg::APB_DW-1:0] prdata,
    output logic                         pready
);
    import grffa_pkg::*;

    logic [CFG_W-1:0] grid_width;
    logic [CFG_W-1:0] grid_height;
    dp_cmd_t          cmd;
    dp_status_t       status;

    // Configuration registers.
    grffa_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .grid_width  (grid_width),
        .grid_height (grid_height)
    );

    // Controller.
    grffa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath.
    grffa_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_kind        (s_kind),
        .s_rect_left   (s_rect_left),
        .s_rect_top    (s_rect_top),
        .s_rect_width  (s_rect_width),
        .s_rect_height (s_rect_height),
        .grid_width    (grid_width),
        .grid_height   (grid_height),
        .cmd           (cmd),
        .status        (status),
        .m_ok          (m_ok),
        .m_place_left  (m_place_left),
        .m_place_top   (m_place_top)
    );

endmodule

FILE: rtl/grffa_checker.sv
// Port-level checker for the allocator, attached to the top level by bind.
module grffa_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_ok,
    input logic [grffa_pkg::POS_W-1:0]  m_place_left,
    input logic [grffa_pkg::POS_W-1:0]  m_place_top
);

    // A stalled result transaction holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_ok)
        && $stable(m_place_left) && $stable(m_place_top))
        else $error("result transaction changed while stalled");

    // Requests are handled one at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while another is in progress");

    // A new result only appears at the end of work, never from the idle state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result raised while the block was idle");

    // Reset leaves the block idle with no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

endmodule

bind grid_rect_first_fit_allocator grffa_checker u_grffa_checker (.*);
